>>> hw/rtl/ifla_pkg.sv
package ifla_pkg;

   localparam int CAPACITY_DEF   = 256;
   localparam int ELEM_WIDTH_DEF = 32;

   localparam int OP_W       = 3;
   localparam int SLOT_W     = 8;
   localparam int VALUE_W    = 32;
   localparam int RANGE_W    = 9;
   localparam int STATUS_W   = 2;
   localparam int REQ_DATA_W = 40;
   localparam int RSP_DATA_W = 56;
   localparam int RSP_PAD_W  = RSP_DATA_W - SLOT_W - VALUE_W - RANGE_W;

   typedef enum logic [OP_W-1:0] {
      OP_INSERT = 3'd0,
      OP_ERASE  = 3'd1,
      OP_READ   = 3'd2,
      OP_WRITE  = 3'd3,
      OP_CLEAR  = 3'd4
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   typedef struct packed {
      status_type status;
      logic       elem_we;
      logic       rd_ok;
   } ctrl_flags_type;

endpackage

>>> hw/rtl/indexed_free_list_allocator_unit.sv
// Slot store with an indexed free list.
// req channel: one word per request. tuser carries the opcode (insert, erase,
// read, write, clear); tdata carries the slot index and the element value.
// rsp channel: exactly one word per request, in request order. tdata carries
// the allocated slot, the read element and the high-water count after the
// request; tuser carries the status (ok, full, slot out of range).
// A request is loaded into the input register at acceptance, and its response
// into the response register when it executes. While rsp_tready is high the
// throughput is one request per cycle: the element RAM is read at acceptance,
// and the next free-list link is read from the link RAM in the same edge that
// pops the head. Reset empties the free list and the high-water count; the
// element and link RAMs are not cleared, and no unwritten entry is ever
// reachable.
// When rsp_tready is low the response word holds, one more request is taken
// into the input register, and then req_tready drops until rsp drains.
module indexed_free_list_allocator_unit #(
   parameter int CAPACITY   = ifla_pkg::CAPACITY_DEF,
   parameter int ELEM_WIDTH = ifla_pkg::ELEM_WIDTH_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [ifla_pkg::REQ_DATA_W-1:0] req_tdata,  // slot[7:0], value[39:8]
   input  logic [ifla_pkg::OP_W-1:0]       req_tuser,  // op[2:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [ifla_pkg::RSP_DATA_W-1:0] rsp_tdata,  // given_slot[7:0], read_value[39:8],
                                                       // used_range[48:40]
   output logic [ifla_pkg::STATUS_W-1:0]   rsp_tuser   // status[1:0]
);
   import ifla_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int HW_W  = $clog2(CAPACITY + 1);
   localparam int XW    = (ELEM_WIDTH > VALUE_W) ? ELEM_WIDTH : VALUE_W;

   logic                  ex_valid_ff, ex_valid_in;
   op_type                op_ff;
   logic [SLOT_W-1:0]     slot_ff;
   logic [VALUE_W-1:0]    value_ff;

   logic                  byp_hit_ff;
   logic [ELEM_WIDTH-1:0] byp_data_ff;

   logic                  rsp_valid_ff;
   logic [RSP_DATA_W-1:0] rsp_data_ff;
   status_type            rsp_status_ff;

   logic                  advance;
   logic                  fire;
   logic                  accept;
   logic [SLOT_W-1:0]     req_slot;
   logic [IDX_W-1:0]      req_idx;

   logic [IDX_W-1:0]      given_slot;
   logic [IDX_W-1:0]      elem_addr;
   logic [HW_W-1:0]       hw_next;
   ctrl_flags_type        flags;

   logic [XW-1:0]         value_x;
   logic [ELEM_WIDTH-1:0] elem_wdata;
   logic [ELEM_WIDTH-1:0] elem_rdata;
   logic [ELEM_WIDTH-1:0] rd_elem;
   logic [XW-1:0]         rd_x;
   logic [VALUE_W-1:0]    read_value;

   assign advance     = !rsp_valid_ff || rsp_tready;
   assign fire        = ex_valid_ff && advance;
   assign req_tready  = !ex_valid_ff || advance;
   assign accept      = req_tvalid && req_tready;
   assign req_slot    = req_tdata[SLOT_W-1:0];
   assign req_idx     = IDX_W'(req_slot);
   assign ex_valid_in = accept ? 1'b1 : (fire ? 1'b0 : ex_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ex_valid_ff <= 1'b0;
      end else begin
         ex_valid_ff <= ex_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff       <= op_type'(req_tuser);
         slot_ff     <= req_slot;
         value_ff    <= req_tdata[SLOT_W +: VALUE_W];
         // write landing in the same edge as this read
         byp_hit_ff  <= flags.elem_we && (elem_addr == req_idx);
         byp_data_ff <= elem_wdata;
      end
   end

   ifla_slot_ctrl #(
      .CAPACITY (CAPACITY)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .op         (op_ff),
      .slot       (slot_ff),
      .given_slot (given_slot),
      .elem_addr  (elem_addr),
      .high_water (hw_next),
      .flags      (flags)
   );

   assign value_x    = XW'(value_ff);
   assign elem_wdata = value_x[ELEM_WIDTH-1:0];

   ifla_ram #(
      .WIDTH (ELEM_WIDTH),
      .DEPTH (CAPACITY)
   ) u_elem_ram (
      .clock (clock),
      .we    (flags.elem_we),
      .waddr (elem_addr),
      .wdata (elem_wdata),
      .re    (accept),
      .raddr (req_idx),
      .rdata (elem_rdata)
   );

   assign rd_elem    = byp_hit_ff ? byp_data_ff : elem_rdata;
   assign rd_x       = XW'(rd_elem);
   assign read_value = flags.rd_ok ? rd_x[VALUE_W-1:0] : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff   <= {{RSP_PAD_W{1'b0}}, RANGE_W'(hw_next), read_value,
                           SLOT_W'(given_slot)};
         rsp_status_ff <= flags.status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_status_ff;

   a_hw_bound: assert property (@(posedge clock) disable iff (reset)
      hw_next <= HW_W'(CAPACITY))
      else $error("high-water count beyond capacity");

   a_full_only_at_cap: assert property (@(posedge clock) disable iff (reset)
      fire && flags.status == ST_FULL |-> hw_next == HW_W'(CAPACITY))
      else $error("full reported below capacity");

   a_no_write_on_error: assert property (@(posedge clock) disable iff (reset)
      fire && flags.status != ST_OK |-> !flags.elem_we)
      else $error("element written on a failed request");

   a_given_in_range: assert property (@(posedge clock) disable iff (reset)
      fire && op_ff == OP_INSERT && flags.status == ST_OK
         |-> HW_W'(given_slot) < hw_next)
      else $error("allocated slot outside the high-water range");

   a_rsp_follows_fire: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("response lost after execution");

endmodule

>>> hw/rtl/ifla_ram.sv
module ifla_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rd_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rd_ff;

endmodule

>>> hw/rtl/ifla_slot_ctrl.sv
module ifla_slot_ctrl #(
   parameter int CAPACITY = ifla_pkg::CAPACITY_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  ifla_pkg::op_type              op,
   input  logic [ifla_pkg::SLOT_W-1:0]   slot,
   output logic [$clog2(CAPACITY)-1:0]   given_slot,
   output logic [$clog2(CAPACITY)-1:0]   elem_addr,
   output logic [$clog2(CAPACITY+1)-1:0] high_water,
   output ifla_pkg::ctrl_flags_type      flags
);
   import ifla_pkg::*;

   localparam int IDX_W = $clog2(CAPACITY);
   localparam int HW_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W = (HW_W > SLOT_W) ? HW_W : SLOT_W;

   logic [IDX_W-1:0] head_ff, head_in;
   logic [IDX_W-1:0] link_ff, link_in;
   logic             nonempty_ff, nonempty_in;
   logic             pend_ff, pend_in;
   logic [HW_W-1:0]  hw_ff, hw_in;

   logic [IDX_W-1:0] link_rdata;
   logic [IDX_W-1:0] head_link;
   logic [IDX_W-1:0] slot_idx;
   logic [IDX_W-1:0] link_wdata;
   logic             link_we;
   logic             link_re;
   logic             in_range;
   logic             elem_we;

   // link of the current head: register after erase, RAM word after a pop
   assign head_link = pend_ff ? link_rdata : link_ff;
   assign slot_idx  = IDX_W'(slot);
   assign in_range  = CMP_W'(slot) < CMP_W'(hw_ff);

   always_comb begin
      head_in       = head_ff;
      link_in       = link_ff;
      nonempty_in   = nonempty_ff;
      pend_in       = pend_ff;
      hw_in         = hw_ff;
      link_we       = 1'b0;
      link_re       = 1'b0;
      link_wdata    = nonempty_ff ? head_ff : slot_idx;
      given_slot    = '0;
      elem_addr     = slot_idx;
      elem_we       = 1'b0;
      flags.rd_ok   = 1'b0;
      flags.status  = ST_OK;
      case (op)
         OP_INSERT: begin
            if (nonempty_ff) begin
               given_slot  = head_ff;
               elem_addr   = head_ff;
               elem_we     = 1'b1;
               head_in     = head_link;
               nonempty_in = head_link != head_ff;
               link_re     = 1'b1;
               pend_in     = 1'b1;
            end else if (hw_ff < HW_W'(CAPACITY)) begin
               given_slot = IDX_W'(hw_ff);
               elem_addr  = IDX_W'(hw_ff);
               elem_we    = 1'b1;
               hw_in      = HW_W'(hw_ff + 1'b1);
            end else begin
               flags.status = ST_FULL;
            end
         end
         OP_ERASE: begin
            if (!in_range) begin
               flags.status = ST_RANGE;
            end else begin
               link_we     = 1'b1;
               link_in     = link_wdata;
               head_in     = slot_idx;
               nonempty_in = 1'b1;
               pend_in     = 1'b0;
            end
         end
         OP_READ: begin
            if (!in_range) begin
               flags.status = ST_RANGE;
            end else begin
               flags.rd_ok = 1'b1;
            end
         end
         OP_WRITE: begin
            if (!in_range) begin
               flags.status = ST_RANGE;
            end else begin
               elem_we = 1'b1;
            end
         end
         OP_CLEAR: begin
            hw_in       = '0;
            head_in     = '0;
            nonempty_in = 1'b0;
            pend_in     = 1'b0;
         end
         default: begin
         end
      endcase
      flags.elem_we = elem_we & fire;
   end

   assign high_water    = hw_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         nonempty_ff <= 1'b0;
         pend_ff     <= 1'b0;
         hw_ff       <= '0;
      end else if (fire) begin
         head_ff     <= head_in;
         nonempty_ff <= nonempty_in;
         pend_ff     <= pend_in;
         hw_ff       <= hw_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         link_ff <= link_in;
      end
   end

   ifla_ram #(
      .WIDTH (IDX_W),
      .DEPTH (CAPACITY)
   ) u_link_ram (
      .clock (clock),
      .we    (link_we & fire),
      .waddr (slot_idx),
      .wdata (link_wdata),
      .re    (link_re & fire),
      .raddr (head_link),
      .rdata (link_rdata)
   );

endmodule
